/* hdl/haf_pkg.sv */
package haf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] START_CHAR = 7'h7E;
  localparam logic [CHAR_W-1:0] END_CHAR   = 7'h0D;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETCODE = 2'd3;

  localparam logic [BYTE_W-1:0] VERSION_RST = 8'd32;
  localparam logic [BYTE_W-1:0] ADDRESS_RST = 8'd2;
  localparam logic [BYTE_W-1:0] CLASS_RST   = 8'd70;
  localparam logic [BYTE_W-1:0] RETCODE_RST = 8'd0;

  // character slots of a frame; each field starts at the named slot
  localparam logic [SLOT_W-1:0] SLOT_SOF   = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_VER   = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_ADDR  = 5'd3;
  localparam logic [SLOT_W-1:0] SLOT_CLASS = 5'd5;
  localparam logic [SLOT_W-1:0] SLOT_RET   = 5'd7;
  localparam logic [SLOT_W-1:0] SLOT_LEN   = 5'd9;
  localparam logic [SLOT_W-1:0] SLOT_DATA  = 5'd13;
  localparam logic [SLOT_W-1:0] SLOT_CHK   = 5'd15;
  localparam logic [SLOT_W-1:0] SLOT_EOF   = 5'd19;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

/* hdl/haf_in_if.sv */
interface haf_in_if import haf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  payload_byte;
  logic [COUNT_W-1:0] byte_count;
  logic               final_byte;

  modport source (output valid, payload_byte, byte_count, final_byte, input ready);
  modport sink   (input valid, payload_byte, byte_count, final_byte, output ready);
endinterface

/* hdl/haf_out_if.sv */
interface haf_out_if import haf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              frame_end;

  modport source (output valid, out_char, frame_end, input ready);
  modport sink   (input valid, out_char, frame_end, output ready);
endinterface

/* hdl/hex_ascii_frame_encoder_unit.sv */
// Hex-ASCII frame encoder. Each request on in_ch carries one binary payload
// byte; out_ch gives the ASCII characters of the frame, one per cycle while
// out_ch.ready does not stall it. The first byte of a frame opens it with
// 0x7E, the four header bytes from the config registers (version, address,
// device class, return code) as hex pairs, and a 4-char length field
// (2*byte_count with a check nibble on top). Every byte then goes out as two
// uppercase hex chars, high nibble first. A request with final_byte set
// closes the frame with the 16-bit two's complement checksum of all chars
// after 0x7E (four hex chars) and 0x0D, flagged by frame_end. byte_count is
// sampled only on the first byte of a frame and is not checked against the
// bytes that follow. A request yields two characters mid-frame, fifteen when
// it opens a frame, seven when it closes one, and twenty for a single-byte
// frame. The next request is taken in the cycle its predecessor's last
// character moves into the output register, so back-to-back requests leave
// no bubble. Config writes are only legal while the block is idle.
module hex_ascii_frame_encoder_unit import haf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  haf_in_if.sink               in_ch,
  haf_out_if.source            out_ch
);

  // config registers
  logic [BYTE_W-1:0] version_r, address_r, class_r, retcode_r;

  // frame tracking
  logic inside_frame_r;

  // current request being serialized
  logic               cur_valid_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [BYTE_W-1:0]  cur_byte_r;
  logic [COUNT_W-1:0] cur_count_r;
  logic               cur_last_r;

  // checksum accumulator over the chars between the start char and the checksum
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_end_r;

  logic              advance;
  logic              cur_done;
  logic              accept;
  logic [SLOT_W-1:0] end_slot;
  logic [CHAR_W-1:0] char_nxt;
  logic [3:0]        nib;
  logic [11:0]       lenid;
  logic [3:0]        lchk;
  logic [SUM_W-1:0]  len_word;
  logic [SUM_W-1:0]  chk_word;
  logic              summed;

  assign advance  = !out_valid_r || out_ch.ready;
  assign end_slot = cur_last_r ? SLOT_EOF : (SLOT_DATA + 5'd1);
  assign cur_done = advance && (slot_r == end_slot);
  assign in_ch.ready = !cur_valid_r || cur_done;
  assign accept   = in_ch.valid && in_ch.ready;

  // length field: LENID = 2*count (12 bits), check nibble = -(nibble sum)
  assign lenid    = {cur_count_r, 1'b0};
  assign lchk     = 4'd0 - (lenid[11:8] + lenid[7:4] + lenid[3:0]);
  assign len_word = {lchk, lenid};
  assign chk_word = '0 - sum_r;

  // character for the current slot
  always_comb begin
    nib = 4'd0;
    case (slot_r)
      SLOT_VER:           nib = version_r[7:4];
      SLOT_VER + 5'd1:    nib = version_r[3:0];
      SLOT_ADDR:          nib = address_r[7:4];
      SLOT_ADDR + 5'd1:   nib = address_r[3:0];
      SLOT_CLASS:         nib = class_r[7:4];
      SLOT_CLASS + 5'd1:  nib = class_r[3:0];
      SLOT_RET:           nib = retcode_r[7:4];
      SLOT_RET + 5'd1:    nib = retcode_r[3:0];
      SLOT_LEN:           nib = len_word[15:12];
      SLOT_LEN + 5'd1:    nib = len_word[11:8];
      SLOT_LEN + 5'd2:    nib = len_word[7:4];
      SLOT_LEN + 5'd3:    nib = len_word[3:0];
      SLOT_DATA:          nib = cur_byte_r[7:4];
      SLOT_DATA + 5'd1:   nib = cur_byte_r[3:0];
      SLOT_CHK:           nib = chk_word[15:12];
      SLOT_CHK + 5'd1:    nib = chk_word[11:8];
      SLOT_CHK + 5'd2:    nib = chk_word[7:4];
      SLOT_CHK + 5'd3:    nib = chk_word[3:0];
      default:            nib = 4'd0;
    endcase
    if (slot_r == SLOT_SOF) begin
      char_nxt = START_CHAR;
    end else if (slot_r == SLOT_EOF) begin
      char_nxt = END_CHAR;
    end else begin
      char_nxt = hex_char(nib);
    end
  end

  // header, length and data chars feed the checksum
  assign summed  = (slot_r >= SLOT_VER) && (slot_r < SLOT_CHK);
  assign sum_nxt = (slot_r == SLOT_SOF) ? '0 :
                   summed ? (sum_r + {{(SUM_W-CHAR_W){1'b0}}, char_nxt}) : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r      <= VERSION_RST;
      address_r      <= ADDRESS_RST;
      class_r        <= CLASS_RST;
      retcode_r      <= RETCODE_RST;
      inside_frame_r <= 1'b0;
      cur_valid_r    <= 1'b0;
      slot_r         <= SLOT_SOF;
      sum_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_VERSION: version_r <= cfg_wdata;
          CFG_ADDRESS: address_r <= cfg_wdata;
          CFG_CLASS:   class_r   <= cfg_wdata;
          CFG_RETCODE: retcode_r <= cfg_wdata;
        endcase
      end

      if (advance) begin
        out_valid_r <= cur_valid_r;
      end
      if (advance && cur_valid_r) begin
        sum_r <= sum_nxt;
        if (!cur_done) begin
          slot_r <= slot_r + 5'd1;
        end
      end

      if (accept) begin
        cur_valid_r    <= 1'b1;
        slot_r         <= inside_frame_r ? SLOT_DATA : SLOT_SOF;
        inside_frame_r <= !in_ch.final_byte;
      end else if (cur_done) begin
        cur_valid_r <= 1'b0;
      end
    end
  end

  // payload and output char registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte_r <= in_ch.payload_byte;
      cur_last_r <= in_ch.final_byte;
      if (!inside_frame_r) begin
        cur_count_r <= in_ch.byte_count;
      end
    end
    if (advance) begin
      out_char_r <= char_nxt;
      out_end_r  <= cur_valid_r && (slot_r == SLOT_EOF);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.frame_end = out_end_r;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (slot_r <= SLOT_EOF))
    else $error("slot counter out of range");

  a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_char_r == END_CHAR))
    else $error("frame_end on a char other than 0x0D");

  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_valid_r && (slot_r == SLOT_SOF)) |=> (sum_r == '0))
    else $error("checksum not cleared at frame start");

  a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && (slot_r >= SLOT_CHK)) |-> (cur_last_r && !inside_frame_r))
    else $error("trailer emitted on a non-final request");
`endif

endmodule

/* test/testbench.sv */
// Frame encoder bench: directed frames with a few hand-decoded golden frames,
// then random frames across several header register settings. Each char
// that leaves the block is checked against its golden frame if it has one,
// else against a software encoder with its own frame state and char sum.
module testbench;
  import haf_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES = 30;   // drain margin at phase ends and at the end

  // one character of a frame as it should leave the block
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eof;
  } frame_char_t;

  // one row of the directed table
  typedef struct packed {
    logic [BYTE_W-1:0]  payload;
    logic [COUNT_W-1:0] count;
    logic               last;
  } byte_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [BYTE_W-1:0]    cfg_wdata;

  haf_in_if  in_ch ();
  haf_out_if out_ch ();

  hex_ascii_frame_encoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder shadow: header registers, frame state and the running sum of the
  // header, length and data characters after the start character.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] hdr_regs [4];
  bit                frame_open;
  logic [SUM_W-1:0]  frame_sum;

  frame_char_t pending_chars [$];  // characters still owed by the block
  frame_char_t new_chars [$];      // characters caused by the latest request

  int mismatch_count;
  int sender_idle_pct;
  int sink_idle_pct;

  // directed table
  byte_row_t directed_rows [$];
  string     directed_golden [$];

  function automatic logic [CHAR_W-1:0] ascii_hex(input logic [3:0] nib);
    logic [7:0] code;
    if (nib > 4'd9) begin
      code = 8'h41 + {4'h0, nib} - 8'd10;
    end else begin
      code = 8'h30 + {4'h0, nib};
    end
    return code[CHAR_W-1:0];
  endfunction

  function automatic void put_char(input logic [CHAR_W-1:0] c, input logic eof,
                                   input bit summed);
    new_chars.push_back('{ch: c, eof: eof});
    if (summed) frame_sum = frame_sum + {{(SUM_W-CHAR_W){1'b0}}, c};
  endfunction

  function automatic void put_hex_pair(input logic [7:0] v, input bit summed);
    put_char(ascii_hex(v[7:4]), 1'b0, summed);
    put_char(ascii_hex(v[3:0]), 1'b0, summed);
  endfunction

  // Characters caused by one accepted request, left in new_chars.
  function automatic void encode_byte(input logic [BYTE_W-1:0] payload,
                                      input logic [COUNT_W-1:0] count,
                                      input logic last);
    logic [11:0]      len_ascii;
    logic [5:0]       nib_total;
    logic [3:0]       len_check;
    logic [SUM_W-1:0] frame_check;
    new_chars.delete();
    if (!frame_open) begin
      // header: start char is not part of the sum, the header chars after it are
      frame_sum = '0;
      put_char(START_CHAR, 1'b0, 1'b0);
      put_hex_pair(hdr_regs[CFG_VERSION], 1'b1);
      put_hex_pair(hdr_regs[CFG_ADDRESS], 1'b1);
      put_hex_pair(hdr_regs[CFG_CLASS], 1'b1);
      put_hex_pair(hdr_regs[CFG_RETCODE], 1'b1);
      // ASCII length is twice the byte count, kept to 12 bits
      len_ascii = {count, 1'b0};
      nib_total = {2'b00, len_ascii[11:8]} + {2'b00, len_ascii[7:4]}
                + {2'b00, len_ascii[3:0]};
      len_check = 4'd0 - nib_total[3:0];
      put_hex_pair({len_check, len_ascii[11:8]}, 1'b1);
      put_hex_pair(len_ascii[7:0], 1'b1);
      frame_open = 1'b1;
    end
    put_hex_pair(payload, 1'b1);
    if (last) begin
      // trailer: negated 16-bit sum, then CR flagged as frame end
      frame_check = '0 - frame_sum;
      put_hex_pair(frame_check[15:8], 1'b0);
      put_hex_pair(frame_check[7:0], 1'b0);
      put_char(END_CHAR, 1'b1, 1'b0);
      frame_open = 1'b0;
      frame_sum  = '0;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Inputs move on the falling edge; acceptance is seen at the
  // rising edge. valid stays high across back-to-back requests.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] payload,
                           input logic [COUNT_W-1:0] count,
                           input logic last, input string golden);
    int  gap;
    byte b;
    gap = pick_gap(sender_idle_pct);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.payload_byte = payload;
    in_ch.byte_count   = count;
    in_ch.final_byte   = last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    encode_byte(payload, count, last);
    if (golden.len() == 0) begin
      foreach (new_chars[i]) pending_chars.push_back(new_chars[i]);
    end else begin
      // hand-decoded frame; the CR is always the last char
      for (int i = 0; i < golden.len(); i++) begin
        b = golden[i];
        pending_chars.push_back('{ch: b[CHAR_W-1:0], eof: 1'b0});
      end
      pending_chars.push_back('{ch: END_CHAR, eof: 1'b1});
    end
    @(negedge clk);
  endtask

  task automatic add_row(input logic [BYTE_W-1:0] payload,
                         input logic [COUNT_W-1:0] count,
                         input logic last, input string golden);
    directed_rows.push_back('{payload: payload, count: count, last: last});
    directed_golden.push_back(golden);
  endtask

  // stop sending and let every owed character come out
  task automatic drain;
    in_ch.valid = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    hdr_regs[idx] = v;
  endtask

  task automatic write_header(input logic [BYTE_W-1:0] ver, input logic [BYTE_W-1:0] addr,
                              input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] ret);
    write_reg(CFG_VERSION, ver);
    write_reg(CFG_ADDRESS, addr);
    write_reg(CFG_CLASS, cls);
    write_reg(CFG_RETCODE, ret);
  endtask

  // Random whole frames. Most carry a byte count that matches; the rest lie
  // about it (zero, full scale or anything), which the block passes through.
  task automatic run_frames(input int n_items);
    int sent;
    int frame_len;
    int pick;
    logic [COUNT_W-1:0] count;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) frame_len = 1;
      else if (pick < 85) frame_len = $urandom_range(2, 8);
      else frame_len = $urandom_range(9, 24);
      pick = $urandom_range(99);
      if (pick < 70) count = COUNT_W'(frame_len);
      else if (pick < 80) count = '1;
      else if (pick < 85) count = '0;
      else count = COUNT_W'($urandom_range(0, 2047));
      for (int i = 0; i < frame_len; i++) begin
        // later bytes carry junk counts, which must be ignored
        send_byte(BYTE_W'($urandom_range(255)),
                  (i == 0) ? count : COUNT_W'($urandom_range(0, 2047)),
                  i == frame_len - 1, "");
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, check against the oldest owed char.
  // ---------------------------------------------------------------------------
  initial begin
    frame_char_t owed;
    int          stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected char: expected none, got %h eof %b",
                   $time, out_ch.out_char, out_ch.frame_end);
          mismatch_count++;
        end else begin
          owed = pending_chars.pop_front();
          if (out_ch.out_char !== owed.ch) begin
            $display("%0t: out_char mismatch: expected %h, got %h",
                     $time, owed.ch, out_ch.out_char);
            mismatch_count++;
          end
          if (out_ch.frame_end !== owed.eof) begin
            $display("%0t: frame_end mismatch: expected %b, got %b",
                     $time, owed.eof, out_ch.frame_end);
            mismatch_count++;
          end
        end
      end
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left = pick_gap(sink_idle_pct);
      end
    end
  end

  // Watchdog: a stuck handshake on both sides ends the run.
  int quiet_cycles;
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_VERSION;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.byte_count   = '0;
    in_ch.final_byte   = 1'b0;
    mismatch_count     = 0;
    hdr_regs[CFG_VERSION] = VERSION_RST;
    hdr_regs[CFG_ADDRESS] = ADDRESS_RST;
    hdr_regs[CFG_CLASS]   = CLASS_RST;
    hdr_regs[CFG_RETCODE] = RETCODE_RST;
    frame_open = 1'b0;
    frame_sum  = '0;

    // Directed table. The first two frames use the reset header and are
    // decoded by hand: a single zero byte, and a count of zero (length field
    // 0000, check nibble 0) with an all-ones byte.
    add_row(8'h00, 11'd1, 1'b1, "~20024600E00200FD3B");
    add_row(8'hFF, 11'd0, 1'b1, "~200246000000FFFD26");
    // full-scale count on a two-byte frame: count is not checked
    add_row(8'hA5, 11'd2047, 1'b0, "");
    add_row(8'h5A, 11'd0,    1'b1, "");
    // counts on later bytes are ignored
    add_row(8'h0F, 11'd3,    1'b0, "");
    add_row(8'hF0, 11'h7FF,  1'b0, "");
    add_row(8'h9C, 11'd3,    1'b1, "");
    // 2*1024 sets the top bit of the 12-bit length field
    add_row(8'h12, 11'd1024, 1'b1, "");
    add_row(8'h80, 11'h555,  1'b1, "");
    add_row(8'h7F, 11'h2AA,  1'b1, "");
    // every hex digit in a matched eight-byte frame
    add_row(8'h01, 11'd8, 1'b0, "");
    add_row(8'h23, 11'd0, 1'b0, "");
    add_row(8'h45, 11'd0, 1'b0, "");
    add_row(8'h67, 11'd0, 1'b0, "");
    add_row(8'h89, 11'd0, 1'b0, "");
    add_row(8'hAB, 11'd0, 1'b0, "");
    add_row(8'hCD, 11'd0, 1'b0, "");
    add_row(8'hEF, 11'd0, 1'b1, "");

    sender_idle_pct = 20;
    sink_idle_pct   = 20;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].payload, directed_rows[i].count,
                directed_rows[i].last, directed_golden[i]);

    // Random phases; each one drains first so the header is only rewritten
    // while the block is idle. The drain is also the sender's full pause.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_header(8'h00, 8'h00, 8'h00, 8'h00);
          sender_idle_pct = 0;   // a stretch with no idling on either side
          sink_idle_pct   = 0;
        end
        1: begin
          write_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);
          sender_idle_pct = 30;
          sink_idle_pct   = 30;
        end
        2: begin
          write_header(BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom), BYTE_W'($urandom));
          sender_idle_pct = 10;  // receiver is the bottleneck
          sink_idle_pct   = 50;
        end
        3: begin
          write_header(BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom), BYTE_W'($urandom));
          sender_idle_pct = 50;  // sender is the bottleneck
          sink_idle_pct   = 10;
        end
        default: begin
          write_header(VERSION_RST, ADDRESS_RST, CLASS_RST, RETCODE_RST);
          sender_idle_pct = 25;
          sink_idle_pct   = 25;
        end
      endcase
      run_frames(26);
    end

    // wait out the last owed chars, then a margin for strays
    in_ch.valid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
